@@ hw/rtl/conv2d_multichannel_stream_assert.svh @@
// Assertion macros for the streaming 2D convolution block
`ifndef CONV2D_MULTICHANNEL_STREAM_ASSERT_SVH
`define CONV2D_MULTICHANNEL_STREAM_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define C2D_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("c2d assertion failed");
// next-cycle implication
`define C2D_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("c2d assertion failed");
`else
`define C2D_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define C2D_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ hw/rtl/c2d_pkg.sv @@
// Package of types and constants for the streaming 2D convolution block
`default_nettype none
package c2d_pkg;
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_IN_CH  = 8;
	localparam int MAX_OUT_CH = 16;
	localparam int MAX_KERNEL = 5;
	localparam int WDEPTH     = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
	localparam int LDEPTH     = MAX_KERNEL * MAX_WIDTH * MAX_IN_CH;
	localparam int ACC_W      = 49;
	localparam int NREG       = 6;

	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_BIAS   = 2'd1;
	localparam logic [1:0] OP_SAMPLE = 2'd2;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_KERNEL = 3'd2;
	localparam logic [2:0] REG_STEP   = 3'd3;
	localparam logic [2:0] REG_IN_CH  = 3'd4;
	localparam logic [2:0] REG_OUT_CH = 3'd5;

	typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_WAIT, ST_DRAIN} state_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [11:0]        load_index;
		logic signed [15:0] data_value;
		logic signed [31:0] bias_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] conv_value;
		logic [11:0]        out_row;
		logic [5:0]         out_col;
		logic [3:0]         out_chan;
		logic               last_chan;
		logic               saturated;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;
endpackage
`default_nettype wire

@@ hw/rtl/conv2d_multichannel_stream.sv @@
// Top level of the streaming multichannel 2D convolution block
// Loads and samples that complete no window are accepted back to back while idle.
// A window-completing sample issues O*C*K*K MACs (one weight-memory read
// per cycle), waits for the multiply pipe to empty, then shifts the O results
// out; new requests are stalled until the block is idle again.
// Reset: registers to defaults, positions and bias store to zero; weight and
// line memories are not cleared.
`default_nettype none
`include "conv2d_multichannel_stream_assert.svh"
module conv2d_multichannel_stream (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire c2d_pkg::req_t req_item,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output c2d_pkg::rsp_t      rsp_item,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	localparam int AW = c2d_pkg::ACC_W;

	// configuration registers, kept at their field widths
	logic [6:0]  width_q;
	logic [11:0] height_q;
	logic [2:0]  kernel_q;
	logic [2:0]  step_q;
	logic [3:0]  inch_q;
	logic [4:0]  outch_q;

	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[4:2] < 3'(c2d_pkg::NREG));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 12'd64;
			kernel_q <= 3'd3;
			step_q   <= 3'd1;
			inch_q   <= 4'd1;
			outch_q  <= 5'd1;
		end else if (psel & penable & pwrite) begin
			case (paddr[4:2])
				c2d_pkg::REG_WIDTH:  width_q  <= pwdata[6:0];
				c2d_pkg::REG_HEIGHT: height_q <= pwdata[11:0];
				c2d_pkg::REG_KERNEL: kernel_q <= pwdata[2:0];
				c2d_pkg::REG_STEP:   step_q   <= pwdata[2:0];
				c2d_pkg::REG_IN_CH:  inch_q   <= pwdata[3:0];
				c2d_pkg::REG_OUT_CH: outch_q  <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			c2d_pkg::REG_WIDTH:  prdata = {25'd0, width_q};
			c2d_pkg::REG_HEIGHT: prdata = {20'd0, height_q};
			c2d_pkg::REG_KERNEL: prdata = {29'd0, kernel_q};
			c2d_pkg::REG_STEP:   prdata = {29'd0, step_q};
			c2d_pkg::REG_IN_CH:  prdata = {28'd0, inch_q};
			c2d_pkg::REG_OUT_CH: prdata = {27'd0, outch_q};
			default:             prdata = 32'd0;
		endcase
	end

	// effective settings: zero reads as one, oversize saturates
	logic [6:0]  w_c;
	logic [11:0] h_c;
	logic [2:0]  k_c;
	logic [2:0]  s_c;
	logic [3:0]  c_c;
	logic [4:0]  o_c;
	logic [4:0]  kk_c;
	logic [7:0]  n_c;

	always_comb begin
		w_c = (width_q == 7'd0) ? 7'd1 : (width_q > 7'd64 ? 7'd64 : width_q);
		h_c = (height_q == 12'd0) ? 12'd1 : height_q;
		k_c = (kernel_q == 3'd0) ? 3'd1 : (kernel_q > 3'd5 ? 3'd5 : kernel_q);
		s_c = (step_q == 3'd0) ? 3'd1 : step_q;
		c_c = (inch_q == 4'd0) ? 4'd1 : (inch_q > 4'd8 ? 4'd8 : inch_q);
		o_c = (outch_q == 5'd0) ? 5'd1 : (outch_q > 5'd16 ? 5'd16 : outch_q);
		kk_c = {2'd0, k_c} * {2'd0, k_c};
		n_c  = {4'd0, c_c} * {3'd0, kk_c};
	end

	c2d_pkg::state_t state_q, state_d;
	logic req_acc, is_sample, win_hit, can_out, last_issue, o_last;

	assign req_stall = (state_q != c2d_pkg::ST_IDLE);
	assign req_acc   = req_valid & ~req_stall;
	assign is_sample = (req_item.opcode == c2d_pkg::OP_SAMPLE);
	assign can_out   = ~rsp_valid | ~rsp_stall;

	// stream position and stride tracking
	logic [11:0] row_q, orow_q;
	logic [5:0]  col_q, ocol_q;
	logic [2:0]  ch_q, rmod_q, rs_q, cs_q;
	logic [6:0]  col_n;
	logic [12:0] row_n;

	assign col_n = {1'b0, col_q} + 7'd1;
	assign row_n = {1'b0, row_q} + 13'd1;
	assign win_hit = ({1'b0, ch_q} == c_c - 4'd1) && (row_n >= {10'd0, k_c}) &&
		(col_n >= {4'd0, k_c}) && (rs_q == 3'd0) && (cs_q == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0; col_q <= '0; ch_q <= '0; rmod_q <= '0;
			rs_q <= '0; cs_q <= '0; orow_q <= '0; ocol_q <= '0;
		end else if (cfg_wr) begin
			// a register write starts a new frame
			row_q <= '0; col_q <= '0; ch_q <= '0; rmod_q <= '0;
			rs_q <= '0; cs_q <= '0; orow_q <= '0; ocol_q <= '0;
		end else if (req_acc && is_sample) begin
			if ({1'b0, ch_q} + 4'd1 < c_c) begin
				ch_q <= ch_q + 3'd1;
			end else begin
				ch_q <= '0;
				if (col_n >= w_c) begin
					col_q <= '0; cs_q <= '0; ocol_q <= '0;
					if (row_n >= {1'b0, h_c}) begin
						row_q <= '0; rmod_q <= '0; rs_q <= '0; orow_q <= '0;
					end else begin
						row_q  <= row_n[11:0];
						rmod_q <= (rmod_q == 3'd4) ? 3'd0 : rmod_q + 3'd1;
						// stride phase counts only once the window fits
						if (row_n > {10'd0, k_c - 3'd1}) begin
							if (rs_q + 3'd1 == s_c) begin
								rs_q <= '0; orow_q <= orow_q + 12'd1;
							end else begin
								rs_q <= rs_q + 3'd1;
							end
						end else begin
							rs_q <= '0; orow_q <= '0;
						end
					end
				end else begin
					col_q <= col_n[5:0];
					if (col_n > {4'd0, k_c - 3'd1}) begin
						if (cs_q + 3'd1 == s_c) begin
							cs_q <= '0; ocol_q <= ocol_q + 6'd1;
						end else begin
							cs_q <= cs_q + 3'd1;
						end
					end else begin
						cs_q <= '0; ocol_q <= '0;
					end
				end
			end
		end
	end

	// bias store, cleared by reset
	logic signed [31:0] bias_q [c2d_pkg::MAX_OUT_CH];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < c2d_pkg::MAX_OUT_CH; i++) bias_q[i] <= '0;
		end else if (req_acc && req_item.opcode == c2d_pkg::OP_BIAS &&
			req_item.load_index < 12'(c2d_pkg::MAX_OUT_CH)) begin
			bias_q[req_item.load_index[3:0]] <= req_item.bias_value;
		end
	end

	// window sequencer: tap outer, output channel inner
	logic [2:0]  slot0_q, slot_q, tc_q, kh_q, kw_q;
	logic [5:0]  c0_q;
	logic [3:0]  o_q;
	logic [7:0]  t_q;
	logic [11:0] waddr_q, laddr;
	logic [11:0] win_row_q;
	logic [5:0]  win_col_q;
	logic [3:0]  slot_calc;

	assign slot_calc  = {1'b0, rmod_q} + 4'd6 - {1'b0, k_c};
	assign o_last     = ({1'b0, o_q} == o_c - 5'd1);
	assign last_issue = o_last && (t_q == n_c - 8'd1);
	assign laddr      = {slot_q, c0_q + {3'd0, kw_q}, tc_q};

	always_ff @(posedge clk) begin
		if (req_acc && is_sample && win_hit) begin
			slot0_q   <= (slot_calc >= 4'd5) ? 3'(slot_calc - 4'd5) : slot_calc[2:0];
			slot_q    <= (slot_calc >= 4'd5) ? 3'(slot_calc - 4'd5) : slot_calc[2:0];
			c0_q      <= 6'(col_n - {4'd0, k_c});
			win_row_q <= orow_q;
			win_col_q <= ocol_q;
			tc_q <= '0; kh_q <= '0; kw_q <= '0;
			t_q <= '0; waddr_q <= '0;
		end else if (state_q == c2d_pkg::ST_MAC) begin
			if (o_last) begin
				t_q     <= t_q + 8'd1;
				waddr_q <= {4'd0, t_q + 8'd1};
				if (kw_q == k_c - 3'd1) begin
					kw_q <= '0;
					if (kh_q == k_c - 3'd1) begin
						kh_q <= '0; slot_q <= slot0_q; tc_q <= tc_q + 3'd1;
					end else begin
						kh_q   <= kh_q + 3'd1;
						slot_q <= (slot_q == 3'd4) ? 3'd0 : slot_q + 3'd1;
					end
				end else begin
					kw_q <= kw_q + 3'd1;
				end
			end else begin
				waddr_q <= waddr_q + {4'd0, n_c};
			end
		end
	end

	// output channel counter: steps during MAC issue and during shift-out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_q <= '0;
		end else if (state_q == c2d_pkg::ST_MAC ||
			(state_q == c2d_pkg::ST_DRAIN && can_out)) begin
			o_q <= o_last ? 4'd0 : o_q + 4'd1;
		end
	end

	// weight and line memories, registered reads
	logic signed [15:0] wmem [c2d_pkg::WDEPTH];
	logic signed [15:0] lmem [c2d_pkg::LDEPTH];
	logic signed [15:0] w_s1, l_s1;
	logic signed [31:0] prod_s2;
	logic v_s1, v_s2;

	always_ff @(posedge clk) begin
		if (req_acc && req_item.opcode == c2d_pkg::OP_WEIGHT &&
			req_item.load_index < 12'(c2d_pkg::WDEPTH)) begin
			wmem[req_item.load_index] <= req_item.data_value;
		end
		w_s1 <= wmem[waddr_q];
	end

	always_ff @(posedge clk) begin
		if (req_acc && is_sample) begin
			lmem[{rmod_q, col_q, ch_q}] <= req_item.data_value;
		end
		l_s1 <= lmem[laddr];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= w_s1 * l_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == c2d_pkg::ST_MAC);
			v_s2 <= v_s1;
		end
	end

	// chain of accumulator cells; cell 0 always holds the channel now in turn
	logic signed [AW-1:0] acc [c2d_pkg::MAX_OUT_CH];
	logic signed [AW-1:0] sum_new;
	c2d_pkg::cell_ctrl_t  cctl;

	assign sum_new    = acc[0] + {{(AW-32){prod_s2[31]}}, prod_s2};
	assign cctl.load  = req_acc & is_sample & win_hit;
	assign cctl.shift = v_s2 | ((state_q == c2d_pkg::ST_DRAIN) & can_out);

	for (genvar gi = 0; gi < c2d_pkg::MAX_OUT_CH; gi++) begin : g_cell
		logic signed [AW-1:0] nxt;
		logic signed [AW-1:0] init;
		logic                 tail;
		assign init = {{2{bias_q[gi][31]}}, bias_q[gi], 15'd0};
		assign tail = (5'(gi) == o_c - 5'd1);
		if (gi == c2d_pkg::MAX_OUT_CH - 1) begin : g_end
			assign nxt = acc[gi];
		end else begin : g_mid
			assign nxt = acc[gi+1];
		end
		c2d_cell u_cell (
			.clk    (clk),
			.ctrl   (cctl),
			.tail   (tail),
			.init   (init),
			.nxt    (nxt),
			.sum_in (sum_new),
			.acc    (acc[gi])
		);
	end

	// round to nearest (ties up) at Q.15 and saturate to 32 bits
	logic signed [AW:0] rsum;
	logic [34:0]        rq;
	logic               rsat;
	logic signed [31:0] rval;

	always_comb begin
		rsum = {acc[0][AW-1], acc[0]} + (AW+1)'(16384);
		rq   = rsum[AW:15];
		rsat = (rq[34:31] != 4'b0000) && (rq[34:31] != 4'b1111);
		if (rsat) begin
			rval = rq[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			rval = rq[31:0];
		end
	end

	// result register: hold while stalled, load a new item when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (state_q == c2d_pkg::ST_DRAIN && can_out) begin
			rsp_valid <= 1'b1;
		end else if (~rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == c2d_pkg::ST_DRAIN && can_out) begin
			rsp_item.conv_value <= rval;
			rsp_item.out_row    <= win_row_q;
			rsp_item.out_col    <= win_col_q;
			rsp_item.out_chan   <= o_q;
			rsp_item.last_chan  <= o_last;
			rsp_item.saturated  <= rsat;
		end
	end

	// control: idle, issue MACs, drain the pipe, shift results out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= c2d_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			c2d_pkg::ST_IDLE:  if (req_acc && is_sample && win_hit) state_d = c2d_pkg::ST_MAC;
			c2d_pkg::ST_MAC:   if (last_issue) state_d = c2d_pkg::ST_WAIT;
			c2d_pkg::ST_WAIT:  if (!v_s1 && !v_s2) state_d = c2d_pkg::ST_DRAIN;
			c2d_pkg::ST_DRAIN: if (can_out && o_last) state_d = c2d_pkg::ST_IDLE;
			default:           state_d = c2d_pkg::ST_IDLE;
		endcase
	end

	`C2D_ASSERT_IMPLY(a_last_chan, clk, arst_n, rsp_valid && rsp_item.last_chan, rsp_item.out_chan == 4'(o_c - 5'd1))
	`C2D_ASSERT_IMPLY(a_drain_clean, clk, arst_n, state_q == c2d_pkg::ST_DRAIN, !v_s1 && !v_s2)
	`C2D_ASSERT_NEXT(a_win_start, clk, arst_n, req_acc && is_sample && win_hit, state_q == c2d_pkg::ST_MAC)
endmodule
`default_nettype wire

@@ hw/rtl/c2d_cell.sv @@
// One accumulator cell of the output-channel chain
`default_nettype none
module c2d_cell (
	input  wire logic                              clk,
	input  wire c2d_pkg::cell_ctrl_t               ctrl,
	input  wire logic                              tail,
	input  wire logic signed [c2d_pkg::ACC_W-1:0]  init,
	input  wire logic signed [c2d_pkg::ACC_W-1:0]  nxt,
	input  wire logic signed [c2d_pkg::ACC_W-1:0]  sum_in,
	output logic signed [c2d_pkg::ACC_W-1:0]       acc
);
	logic signed [c2d_pkg::ACC_W-1:0] acc_q;

	// load the bias, else take the neighbor's sum, or the fresh sum at the tail
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= init;
		end else if (ctrl.shift) begin
			acc_q <= tail ? sum_in : nxt;
		end
	end

	assign acc = acc_q;
endmodule
`default_nettype wire

@@ dv/conv2d_multichannel_stream_tb.sv @@
// Self-checking testbench for the streaming multichannel 2D convolution block
`timescale 1ns / 100ps
`default_nettype none
module conv2d_multichannel_stream_tb;
	localparam int LIMIT_CYCLES = 3000000;

	logic            clk;
	logic            arst_n;
	logic            req_valid;
	logic            req_stall;
	c2d_pkg::req_t   req_item;
	logic            rsp_valid;
	logic            rsp_stall;
	c2d_pkg::rsp_t   rsp_item;
	logic            psel;
	logic            penable;
	logic            pwrite;
	logic [4:0]      paddr;
	logic [31:0]     pwdata;
	logic [31:0]     prdata;
	logic            pready;

	conv2d_multichannel_stream u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow of the block's settings and stores, kept by the predictor.
	int unsigned cfg_w, cfg_h, cfg_k, cfg_s, cfg_c, cfg_o;
	logic signed [15:0] coef_mem [c2d_pkg::WDEPTH];
	logic signed [31:0] bias_mem [c2d_pkg::MAX_OUT_CH];
	logic signed [15:0] line_mem [c2d_pkg::LDEPTH];
	int unsigned        pos_row, pos_col, pos_ch;

	c2d_pkg::rsp_t conv_expected [$];
	int            fail_count;
	longint        cycle_count;
	bit            hold_off;
	int            hold_cycles;
	int            burst_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	// Mirror one register write; a write to a defined register also restarts the frame.
	function automatic void shadow_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			c2d_pkg::REG_WIDTH:  cfg_w = val[6:0];
			c2d_pkg::REG_HEIGHT: cfg_h = val[11:0];
			c2d_pkg::REG_KERNEL: cfg_k = val[2:0];
			c2d_pkg::REG_STEP:   cfg_s = val[2:0];
			c2d_pkg::REG_IN_CH:  cfg_c = val[3:0];
			c2d_pkg::REG_OUT_CH: cfg_o = val[4:0];
			default: return;
		endcase
		pos_row = 0; pos_col = 0; pos_ch = 0;
	endfunction

	function automatic int unsigned line_addr(int unsigned slot, int unsigned col,
			int unsigned ch);
		return (slot * c2d_pkg::MAX_WIDTH + col) * c2d_pkg::MAX_IN_CH + ch;
	endfunction

	// Predict the outputs of one accepted item and queue them.
	function automatic void conv_predict(c2d_pkg::req_t it);
		int unsigned w, h, k, s, c, o, row, col, ch, r0, c0, wi;
		longint acc, v;
		c2d_pkg::rsp_t r;
		w = clamp_reg(cfg_w, c2d_pkg::MAX_WIDTH);
		h = clamp_reg(cfg_h, 4095);
		k = clamp_reg(cfg_k, c2d_pkg::MAX_KERNEL);
		s = clamp_reg(cfg_s, 7);
		c = clamp_reg(cfg_c, c2d_pkg::MAX_IN_CH);
		o = clamp_reg(cfg_o, c2d_pkg::MAX_OUT_CH);
		if (it.opcode == c2d_pkg::OP_WEIGHT) begin
			if (it.load_index < c2d_pkg::WDEPTH) coef_mem[it.load_index] = it.data_value;
			return;
		end
		if (it.opcode == c2d_pkg::OP_BIAS) begin
			if (it.load_index < c2d_pkg::MAX_OUT_CH)
				bias_mem[it.load_index] = it.bias_value;
			return;
		end
		if (it.opcode != c2d_pkg::OP_SAMPLE) return;
		if (pos_row >= h) pos_row = 0;
		if (pos_col >= w) pos_col = 0;
		if (pos_ch >= c) pos_ch = 0;
		row = pos_row; col = pos_col; ch = pos_ch;
		line_mem[line_addr(row % c2d_pkg::MAX_KERNEL, col, ch)] = it.data_value;
		if (ch == c - 1 && row + 1 >= k && col + 1 >= k &&
				(row + 1 - k) % s == 0 && (col + 1 - k) % s == 0) begin
			r0 = row + 1 - k;
			c0 = col + 1 - k;
			for (int oo = 0; oo < o; oo++) begin
				acc = longint'(bias_mem[oo]) * 32768;
				for (int cc = 0; cc < c; cc++)
					for (int kh = 0; kh < k; kh++)
						for (int kw = 0; kw < k; kw++) begin
							wi = oo * (c * k * k) + cc * (k * k) + kh * k + kw;
							acc += longint'(line_mem[line_addr((r0 + kh) % c2d_pkg::MAX_KERNEL,
								c0 + kw, cc)]) * longint'(coef_mem[wi]);
						end
				v = (acc + 16384) >>> 15;
				r.saturated = 1'b0;
				if (v > 64'sd2147483647) begin
					v = 64'sd2147483647; r.saturated = 1'b1;
				end
				if (v < -64'sd2147483648) begin
					v = -64'sd2147483648; r.saturated = 1'b1;
				end
				r.conv_value = v[31:0];
				r.out_row = 12'(r0 / s);
				r.out_col = 6'(c0 / s);
				r.out_chan = 4'(oo);
				r.last_chan = (oo == o - 1);
				conv_expected.push_back(r);
			end
		end
		pos_ch = ch + 1;
		if (pos_ch >= c) begin
			pos_ch = 0;
			pos_col = col + 1;
			if (pos_col >= w) begin
				pos_col = 0;
				pos_row = row + 1;
				if (pos_row >= h) pos_row = 0;
			end
		end
	endfunction

	// Stall pattern: random, with quiet stretches and the long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_off) begin
			rsp_stall <= 1'b1;
		end else if ((cycle_count / 500) % 3 == 0) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// Count the long hold-off in its own process.
	initial begin
		hold_off = 1'b0;
		wait (hold_cycles > 0);
		hold_off = 1'b1;
		repeat (hold_cycles) @(posedge clk);
		hold_off = 1'b0;
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (conv_expected.size() == 0) begin
				$error("unexpected result %p", rsp_item);
				fail_count++;
			end else begin
				c2d_pkg::rsp_t e;
				e = conv_expected.pop_front();
				if (rsp_item.conv_value !== e.conv_value) begin
					$error("conv_value exp %0d got %0d", e.conv_value, rsp_item.conv_value);
					fail_count++;
				end
				if (rsp_item.out_row !== e.out_row) begin
					$error("out_row exp %0d got %0d", e.out_row, rsp_item.out_row);
					fail_count++;
				end
				if (rsp_item.out_col !== e.out_col) begin
					$error("out_col exp %0d got %0d", e.out_col, rsp_item.out_col);
					fail_count++;
				end
				if (rsp_item.out_chan !== e.out_chan) begin
					$error("out_chan exp %0d got %0d", e.out_chan, rsp_item.out_chan);
					fail_count++;
				end
				if (rsp_item.last_chan !== e.last_chan) begin
					$error("last_chan exp %0b got %0b", e.last_chan, rsp_item.last_chan);
					fail_count++;
				end
				if (rsp_item.saturated !== e.saturated) begin
					$error("saturated exp %0b got %0b", e.saturated, rsp_item.saturated);
					fail_count++;
				end
			end
		end
	end

	// Offer one item and hold it until accepted; burst gaps come from the caller.
	task automatic send_item(c2d_pkg::req_t it);
		req_item <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		conv_predict(it);
	endtask

	task automatic idle_sender();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Send in bursts; drop valid for a random gap when a burst runs out.
	task automatic push_item(c2d_pkg::req_t it);
		if (burst_left <= 0) begin
			if ($urandom_range(0, 2) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		send_item(it);
	endtask

	task automatic push_op(logic [1:0] op, int unsigned idx, logic [15:0] d, logic [31:0] b);
		c2d_pkg::req_t it;
		it.opcode = op;
		it.load_index = 12'(idx);
		it.data_value = d;
		it.bias_value = b;
		push_item(it);
	endtask

	// Wait until no result is pending, then give the block time to settle.
	task automatic drain();
		idle_sender();
		while (conv_expected.size() != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		shadow_reg(idx, val);
	endtask

	task automatic set_geometry(int w, int h, int k, int s, int c, int o);
		drain();
		reg_write(c2d_pkg::REG_WIDTH, w);
		reg_write(c2d_pkg::REG_HEIGHT, h);
		reg_write(c2d_pkg::REG_KERNEL, k);
		reg_write(c2d_pkg::REG_STEP, s);
		reg_write(c2d_pkg::REG_IN_CH, c);
		reg_write(c2d_pkg::REG_OUT_CH, o);
	endtask

	// Load every weight and bias the current geometry uses.
	task automatic load_coefs(bit extreme);
		int unsigned k, c, o;
		k = clamp_reg(cfg_k, c2d_pkg::MAX_KERNEL);
		c = clamp_reg(cfg_c, c2d_pkg::MAX_IN_CH);
		o = clamp_reg(cfg_o, c2d_pkg::MAX_OUT_CH);
		for (int i = 0; i < o * c * k * k; i++)
			push_op(c2d_pkg::OP_WEIGHT, i, extreme ? 16'h8000 : 16'($urandom),
				32'($urandom));
		for (int i = 0; i < o; i++)
			push_op(c2d_pkg::OP_BIAS, i, 16'($urandom), extreme ? 32'h7fff_ffff : $urandom);
	endtask

	task automatic send_samples(int n, int mode);
		logic [15:0] d;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: d = 16'($urandom);
				1: d = 16'h8000;
				default: d = ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
			endcase
			push_op(c2d_pkg::OP_SAMPLE, $urandom_range(0, 4095), d, $urandom);
		end
	endtask

	// Extremes: full-scale products, saturation both ways, odd opcodes, bad indexes.
	task automatic test_directed();
		set_geometry(2, 3, 2, 1, 1, 2);
		load_coefs(1'b1);
		send_samples(6, 1);
		push_op(2'd3, 0, 16'hffff, 32'hffff_ffff);
		push_op(c2d_pkg::OP_WEIGHT, 4000, 16'h1234, 0);
		push_op(c2d_pkg::OP_BIAS, 16, 0, 32'h8000_0000);
		push_op(c2d_pkg::OP_BIAS, 0, 0, 32'h8000_0000);
		push_op(c2d_pkg::OP_BIAS, 1, 0, 32'h0);
		send_samples(6, 2);
	endtask

	// Zero and over-range register values, and a kernel larger than the image.
	task automatic test_reg_extremes();
		set_geometry(0, 0, 0, 0, 0, 0);
		load_coefs(1'b0);
		send_samples(4, 0);
		// zero settings read as one, so every sample here completes a window
		set_geometry(127, 4095, 7, 7, 15, 31);
		send_samples(20, 0);
		set_geometry(3, 2, 4, 1, 1, 1);
		send_samples(12, 0);
	endtask

	// Random geometries, mostly small, with random sample content.
	task automatic test_random(int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			int w, h, k, c, o;
			k = $urandom_range(1, 4);
			w = $urandom_range(k, (sent % 5 == 0) ? 64 : 9);
			h = $urandom_range(k, k + 4);
			c = $urandom_range(1, 2);
			o = $urandom_range(1, (k > 2) ? 2 : 8);
			set_geometry(w, h, k, $urandom_range(1, 4), c, o);
			load_coefs(1'b0);
			sent += o * c * k * k + o;
			for (int i = 0; i < 40; i++) begin
				if ($urandom_range(0, 15) == 0)
					push_op(2'($urandom_range(0, 3)), $urandom_range(0, 4095),
						16'($urandom), $urandom);
				else
					send_samples(1, ($urandom_range(0, 9) == 0) ? 2 : 0);
				sent++;
			end
		end
	endtask

	// Fill the block while the receiver holds off.
	task automatic test_backpressure();
		set_geometry(4, 4, 1, 1, 1, 16);
		load_coefs(1'b0);
		hold_cycles = 400;
		send_samples(16, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_item = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		fail_count = 0; cycle_count = 0; hold_cycles = 0; burst_left = 0;
		cfg_w = 64; cfg_h = 64; cfg_k = 3; cfg_s = 1; cfg_c = 1; cfg_o = 1;
		pos_row = 0; pos_col = 0; pos_ch = 0;
		foreach (bias_mem[i]) bias_mem[i] = '0;
		foreach (coef_mem[i]) coef_mem[i] = '0;
		foreach (line_mem[i]) line_mem[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_reg_extremes();
		test_backpressure();
		test_random(330);
		drain();
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
